### hw/rtl/mi3_pkg.sv
package mi3_pkg;

  // Fixed-point format and datapath widths
  localparam int FracBits = 16;
  localparam int EntW     = 32;              // one matrix entry
  localparam int ShW      = 2 * FracBits;    // product scale of Q format
  localparam int PW       = 2 * EntW;        // entry product
  localparam int AW       = PW + 1;          // signed cofactor
  localparam int MagW     = AW - 1;          // cofactor magnitude
  localparam int LoW      = 33;              // low slice of a cofactor
  localparam int HiW      = AW - LoW;        // high signed slice
  localparam int DetW     = 99;              // signed determinant
  localparam int DmW      = DetW - 1;        // determinant magnitude
  localparam int QW       = EntW;            // quotient bits
  localparam int ThrW     = 31;              // threshold register
  localparam int NCof     = 9;

  typedef logic signed [EntW-1:0] ent_t;
  typedef logic signed [AW-1:0]   adj_t;

  typedef struct packed {
    ent_t m00; ent_t m01; ent_t m02;
    ent_t m10; ent_t m11; ent_t m12;
    ent_t m20; ent_t m21; ent_t m22;
  } mat_t;

  typedef struct packed {
    ent_t inv00; ent_t inv01; ent_t inv02;
    ent_t inv10; ent_t inv11; ent_t inv12;
    ent_t inv20; ent_t inv21; ent_t inv22;
    ent_t determinant;
    logic singular;
  } res_t;

  // Cofactor stage result
  typedef struct packed {
    ent_t [2:0]      row0;
    adj_t [NCof-1:0] adj;
  } cof_res_t;

  // Determinant stage result, also carried alongside the divider
  typedef struct packed {
    logic                      sing;
    logic                      dneg;
    logic [DmW-1:0]            dmag;
    logic [NCof-1:0][MagW-1:0] amag;
    logic [NCof-1:0]           aneg;
  } det_res_t;

  // Cofactor k = a[i]*a[j] - a[m]*a[n], entries in row-major order
  localparam int unsigned CofIdx [NCof][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // Magnitude plus sign to saturated signed entry
  function automatic ent_t sat_q(input logic ovf, input logic [QW-1:0] mag, input logic neg);
    ent_t r;
    if (neg) begin
      if (ovf || (mag > {1'b1, {(QW-1){1'b0}}})) begin
        r = {1'b1, {(EntW-1){1'b0}}};
      end else begin
        r = ent_t'(~mag + 1'b1);
      end
    end else begin
      if (ovf || mag[QW-1]) begin
        r = {1'b0, {(EntW-1){1'b1}}};
      end else begin
        r = ent_t'(mag);
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/matrix_inverse_3x3_top.sv
// Channel   Direction  Signals                              Transfer when
// input     in         in_valid_i, in_ready_o, in_data_i    in_valid_i & in_ready_o
// output    out        out_valid_o, out_ready_i, out_data_o out_valid_o & out_ready_i
// config    in         cfg_we_i, cfg_wdata_i                cfg_we_i
//
// One matrix enters per cycle while the output is not stalled. Stages: 2 cofactor
// stages, 4 determinant stages, 33 divider stages (an overflow check, then one quotient
// bit each) and the output register. The 32-step restoring divider sets the depth.
// Reset clears all stage valid bits and sets the threshold to 1.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module matrix_inverse_3x3_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mi3_pkg::mat_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mi3_pkg::res_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [mi3_pkg::ThrW-1:0] cfg_wdata_i
);
  import mi3_pkg::*;

  logic                      en;
  logic [ThrW-1:0]           thr_q;
  logic                      cof_v, det_v, div_v;
  cof_res_t                  cof_res;
  det_res_t                  det_res, div_side;
  logic [NCof-1:0]           div_ovf;
  logic [NCof-1:0][QW-1:0]   div_quot;
  ent_t                      inv [NCof];
  logic [DmW-ShW-1:0]        dsh;
  res_t                      out_d, out_q;
  logic                      out_v_q;

  // Advance everything when the output register can take a transfer
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  mi3_cofactor u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .valid_o (cof_v),
    .res_o   (cof_res)
  );

  mi3_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_v),
    .cof_i   (cof_res),
    .thr_i   (thr_q),
    .valid_o (det_v),
    .res_o   (det_res)
  );

  mi3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_v),
    .det_i   (det_res),
    .valid_o (div_v),
    .det_o   (div_side),
    .ovf_o   (div_ovf),
    .quot_o  (div_quot)
  );

  // Saturate quotients and determinant, zero everything when singular
  assign dsh = div_side.dmag[DmW-1:ShW];
  always_comb begin
    for (int k = 0; k < NCof; k++) begin
      inv[k] = div_side.sing ? '0
             : sat_q(div_ovf[k], div_quot[k], div_side.aneg[k] ^ div_side.dneg);
    end
    out_d.inv00 = inv[0]; out_d.inv01 = inv[1]; out_d.inv02 = inv[2];
    out_d.inv10 = inv[3]; out_d.inv11 = inv[4]; out_d.inv12 = inv[5];
    out_d.inv20 = inv[6]; out_d.inv21 = inv[7]; out_d.inv22 = inv[8];
    out_d.determinant = div_side.sing ? '0
                      : sat_q(|dsh[DmW-ShW-1:QW], dsh[QW-1:0], div_side.dneg);
    out_d.singular    = div_side.sing;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/mi3_cofactor.sv
module mi3_cofactor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mi3_pkg::mat_t     mat_i,
  output logic              valid_o,
  output mi3_pkg::cof_res_t res_o
);
  import mi3_pkg::*;

  ent_t                a [9];
  logic signed [PW-1:0] prod_d [2*NCof];
  logic signed [PW-1:0] prod_q [2*NCof];
  ent_t [2:0]           row_q;
  logic                 v1_q, v2_q;
  cof_res_t             res_d, res_q;

  // Unpack entries
  always_comb begin
    a[0] = mat_i.m00; a[1] = mat_i.m01; a[2] = mat_i.m02;
    a[3] = mat_i.m10; a[4] = mat_i.m11; a[5] = mat_i.m12;
    a[6] = mat_i.m20; a[7] = mat_i.m21; a[8] = mat_i.m22;
  end

  // Stage 1: the eighteen entry products
  always_comb begin
    for (int k = 0; k < NCof; k++) begin
      prod_d[2*k]   = a[CofIdx[k][0]] * a[CofIdx[k][1]];
      prod_d[2*k+1] = a[CofIdx[k][2]] * a[CofIdx[k][3]];
    end
  end

  // Stage 2: cofactor differences
  always_comb begin
    res_d.row0 = row_q;
    for (int k = 0; k < NCof; k++) begin
      res_d.adj[k] = $signed({prod_q[2*k][PW-1], prod_q[2*k]})
                   - $signed({prod_q[2*k+1][PW-1], prod_q[2*k+1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      row_q  <= {a[2], a[1], a[0]};
      res_q  <= res_d;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule

### hw/rtl/mi3_det.sv
module mi3_det (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  mi3_pkg::cof_res_t          cof_i,
  input  logic [mi3_pkg::ThrW-1:0]   thr_i,
  output logic                       valid_o,
  output mi3_pkg::det_res_t          res_o
);
  import mi3_pkg::*;

  localparam int PlW = EntW + LoW + 1;

  logic signed [PlW-1:0]  pl_d [3], pl_q [3];
  logic signed [PW-1:0]   ph_d [3], ph_q [3];
  logic signed [DetW-1:0] term_d [3], term_q [3];
  logic signed [DetW-1:0] det_d, det_q;
  adj_t [NCof-1:0]        adj3_q, adj4_q, adj5_q;
  logic [DetW-1:0]        dabs;
  logic [AW-1:0]          aabs;
  logic [DmW-1:0]         lim;
  det_res_t               res_d, res_q;
  logic [3:0]             v_q;

  // Stage 3: split cofactor multiplies for the expansion along row 0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_d[k] = $signed(cof_i.row0[k]) * $signed({1'b0, cof_i.adj[3*k][LoW-1:0]});
      ph_d[k] = $signed(cof_i.row0[k]) * $signed(cof_i.adj[3*k][AW-1:LoW]);
    end
  end

  // Stage 4: recombine partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_d[k] = (DetW'(ph_q[k]) <<< LoW) + DetW'(pl_q[k]);
    end
  end

  // Stage 5: sum of the three terms
  assign det_d = term_q[0] + term_q[1] + term_q[2];

  // Stage 6: magnitudes, signs and singular test
  assign lim = {{(DmW-ThrW-ShW){1'b0}}, thr_i, {ShW{1'b0}}};
  always_comb begin
    dabs       = det_q[DetW-1] ? (~det_q + 1'b1) : det_q;
    res_d.dneg = det_q[DetW-1];
    res_d.dmag = dabs[DmW-1:0];
    res_d.sing = (res_d.dmag == '0) || (res_d.dmag < lim);
    aabs       = '0;
    for (int k = 0; k < NCof; k++) begin
      aabs          = adj5_q[k][AW-1] ? (~adj5_q[k] + 1'b1) : adj5_q[k];
      res_d.amag[k] = aabs[MagW-1:0];
      res_d.aneg[k] = adj5_q[k][AW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      adj3_q <= cof_i.adj;
      term_q <= term_d;
      adj4_q <= adj3_q;
      det_q  <= det_d;
      adj5_q <= adj4_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = v_q[3];
  assign res_o   = res_q;

endmodule

### hw/rtl/mi3_divider.sv
module mi3_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  mi3_pkg::det_res_t        det_i,
  output logic                     valid_o,
  output mi3_pkg::det_res_t        det_o,
  output logic [mi3_pkg::NCof-1:0] ovf_o,
  output logic [mi3_pkg::NCof-1:0][mi3_pkg::QW-1:0] quot_o
);
  import mi3_pkg::*;

  localparam int NSt = QW + 1;

  logic [DmW-1:0]  rem_q  [NSt][NCof];
  logic [DmW-1:0]  rem_d  [NSt][NCof];
  logic [QW-1:0]   quot_q [NSt][NCof];
  logic [QW-1:0]   quot_d [NSt][NCof];
  det_res_t        side_q [NSt];
  logic [NCof-1:0] ovf_q  [NSt];
  logic [NCof-1:0] ovf_d;
  logic [NSt-1:0]  v_q;
  logic [DmW+1:0]  diff;
  logic [DmW-1:0]  ext;

  // Entry stage: quotient overflow check, remainder starts at |cofactor|;
  // then one restoring step per stage, one quotient bit each
  always_comb begin
    ext  = '0;
    diff = '0;
    for (int k = 0; k < NCof; k++) begin
      ext         = {{(DmW-MagW){1'b0}}, det_i.amag[k]};
      ovf_d[k]    = (ext >= det_i.dmag);
      rem_d[0][k] = ext;
      quot_d[0][k] = '0;
    end
    for (int s = 1; s < NSt; s++) begin
      for (int k = 0; k < NCof; k++) begin
        diff = {1'b0, rem_q[s-1][k], 1'b0} - {2'b00, side_q[s-1].dmag};
        if (diff[DmW+1]) begin
          rem_d[s][k]  = {rem_q[s-1][k][DmW-2:0], 1'b0};
          quot_d[s][k] = {quot_q[s-1][k][QW-2:0], 1'b0};
        end else begin
          rem_d[s][k]  = diff[DmW-1:0];
          quot_d[s][k] = {quot_q[s-1][k][QW-2:0], 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= det_i;
      ovf_q[0]  <= ovf_d;
      for (int s = 1; s < NSt; s++) begin
        side_q[s] <= side_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  // Drive the last stage
  always_comb begin
    for (int k = 0; k < NCof; k++) begin
      quot_o[k] = quot_q[NSt-1][k];
    end
  end

  assign valid_o = v_q[NSt-1];
  assign det_o   = side_q[NSt-1];
  assign ovf_o   = ovf_q[NSt-1];

endmodule

### hw/rtl/mi3_checker.sv
module mi3_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input mi3_pkg::res_t            out_data_o
);
  import mi3_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Block input transfers while the output is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(in_ready_o && in_valid_i) && !in_ready_o)
    else $error("input taken during output stall");

  // Take input whenever the output is free
  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with free output");

  // Zero the determinant and inv00, inv01, inv11, inv22 of a singular matrix
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.determinant == '0 && out_data_o.inv00 == '0 &&
      out_data_o.inv11 == '0 && out_data_o.inv22 == '0 && out_data_o.inv01 == '0)
    else $error("singular result not zeroed");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (.*);

### sim/matrix_inverse_3x3_top_tb.sv
module matrix_inverse_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mi3_pkg::*;

  localparam int WideW = 130;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 50;
  localparam int RandPerPhase = 280;

  typedef logic signed [WideW-1:0] wide_t;

  typedef struct {
    mat_t m;
    bit   known;
    res_t r;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;

  logic [ThrW-1:0] thr_model = 31'd1;
  res_t pending_q[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_sing = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  vec_t directed[$];

  matrix_inverse_3x3_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Saturate a magnitude with sign to one Q entry
  function automatic ent_t clamp_q(input wide_t mag, input logic neg);
    if (neg) return (mag > wide_t'(64'h8000_0000)) ? ent_t'(32'h8000_0000) : ent_t'(-mag);
    return (mag > wide_t'(64'h7FFF_FFFF)) ? ent_t'(32'h7FFF_FFFF) : ent_t'(mag);
  endfunction

  // Exact inverse by adjugate over the current threshold
  function automatic res_t invert(input mat_t m);
    wide_t a[9];
    wide_t adj[9];
    wide_t det, dmag, lim, amag;
    logic [10*EntW:0] flat;
    res_t r;
    for (int i = 0; i < 9; i++) a[i] = wide_t'(ent_t'(m[287-32*i -: 32]));
    for (int k = 0; k < 9; k++)
      adj[k] = a[CofIdx[k][0]] * a[CofIdx[k][1]] - a[CofIdx[k][2]] * a[CofIdx[k][3]];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    dmag = (det < 0) ? -det : det;
    lim = wide_t'(thr_model) << ShW;
    flat = '0;
    if (dmag == 0 || dmag < lim) begin
      flat[0] = 1'b1;
    end else begin
      for (int k = 0; k < 9; k++) begin
        amag = (adj[k] < 0) ? -adj[k] : adj[k];
        flat[320-32*k -: 32] = clamp_q(wide_t'(unsigned'(amag << ShW) / unsigned'(dmag)),
                                       (adj[k] < 0) != (det < 0));
      end
      flat[32:1] = clamp_q(dmag >>> ShW, det < 0);
    end
    r = res_t'(flat);
    return r;
  endfunction

  function automatic mat_t diag(input ent_t d);
    mat_t m;
    m = '0;
    m.m00 = d; m.m11 = d; m.m22 = d;
    return m;
  endfunction

  function automatic ent_t rand_ent();
    case ($urandom_range(0, 3))
      0: return ent_t'($urandom);
      1: return ent_t'($urandom_range(0, 32'h0008_0000)) - ent_t'(32'h0004_0000);
      2: return ent_t'($urandom_range(0, 32'h0400_0000)) - ent_t'(32'h0200_0000);
      default: return ent_t'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    for (int i = 0; i < 9; i++) m[287-32*i -: 32] = rand_ent();
    // Occasionally force a rank-deficient matrix
    if ($urandom_range(0, 9) == 0) begin
      m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    end
    return m;
  endfunction

  // Present one matrix and hold it until the transfer
  task automatic send(input mat_t m);
    in_valid_i <= 1'b1;
    in_data_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.insert(pending_q.size(), invert(m));
    n_in++;
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Drain the pipeline, then write the threshold
  task automatic set_threshold(input logic [ThrW-1:0] v);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_model = v;
  endtask

  // Receiver stall pattern
  always @(negedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 28);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    logic [10*EntW:0] w, g;
    string names[10];
    names = '{"inv00", "inv01", "inv02", "inv10", "inv11", "inv12",
              "inv20", "inv21", "inv22", "determinant"};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        want = pending_q.pop_front();
        w = want;
        g = out_data_o;
        n_out++;
        if (g[0]) n_sing++;
        for (int i = 0; i < 10; i++)
          if (w[320-32*i -: 32] !== g[320-32*i -: 32]) begin
            $error("%s expected %h got %h", names[i], w[320-32*i -: 32], g[320-32*i -: 32]);
            errors++;
          end
        if (w[0] !== g[0]) begin
          $error("singular expected %b got %b", w[0], g[0]);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("matrix_inverse_3x3_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    vec_t v;
    logic [ThrW-1:0] thr_list[5];
    mat_t m;
    thr_list = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd1, 31'd0};
    thr_list[4] = 31'($urandom);

    // Directed rows; expectations typed in where obvious
    v.known = 1'b1;
    v.m = '0; v.r = '0; v.r.singular = 1'b1; directed.insert(directed.size(), v);
    v.m = diag(32'h0001_0000); v.r = '0;
    v.r.inv00 = 32'h0001_0000; v.r.inv11 = 32'h0001_0000; v.r.inv22 = 32'h0001_0000;
    v.r.determinant = 32'h0001_0000; directed.insert(directed.size(), v);
    v.m = diag(32'hFFFF_0000); v.r = '0;
    v.r.inv00 = 32'hFFFF_0000; v.r.inv11 = 32'hFFFF_0000; v.r.inv22 = 32'hFFFF_0000;
    v.r.determinant = 32'hFFFF_0000; directed.insert(directed.size(), v);
    v.m = {9{32'h7FFF_FFFF}}; v.r = '0; v.r.singular = 1'b1;
    directed.insert(directed.size(), v);
    v.m = {9{32'h8000_0000}}; v.r = '0; v.r.singular = 1'b1;
    directed.insert(directed.size(), v);
    v.m = diag(32'd1); v.r = '0; v.r.singular = 1'b1; directed.insert(directed.size(), v);
    v.known = 1'b0;
    v.m = diag(32'h0002_0000); directed.insert(directed.size(), v);
    v.m = diag(32'h7FFF_FFFF); directed.insert(directed.size(), v);
    v.m = diag(32'h8000_0000); directed.insert(directed.size(), v);
    v.m = diag(32'h0000_0100); directed.insert(directed.size(), v);
    m = '0; m.m02 = 32'h0001_0000; m.m11 = 32'h8000_0000; m.m20 = 32'h7FFF_FFFF;
    v.m = m; directed.insert(directed.size(), v);
    m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000,
         32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0000_0000};
    v.m = m; directed.insert(directed.size(), v);
    v.m = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333,
           32'hCCCC_CCCC, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678};
    directed.insert(directed.size(), v);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: check typed expectations against the predictor, then queue them
    foreach (directed[i]) begin
      if (directed[i].known && invert(directed[i].m) !== directed[i].r) begin
        $error("directed row %0d: typed expectation disagrees", i);
        errors++;
      end
      if (directed[i].known) begin
        send(directed[i].m);
        pending_q[pending_q.size()-1] = directed[i].r;
      end else begin
        send(directed[i].m);
      end
    end

    // Random phases over several thresholds; one phase without idling
    for (int p = 0; p < 5; p++) begin
      set_threshold(thr_list[p]);
      no_idle = (p == 2);
      for (int i = 0; i < RandPerPhase; i++) begin
        if (p == 0 && i < 20) send(diag(ent_t'($urandom_range(0, 3))));
        else send(rand_mat());
      end
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d matrices over 6 threshold settings, %0d results (%0d singular).",
             n_in, n_out, n_sing);
    if (errors == 0) begin
      $display("matrix_inverse_3x3_top_tb: PASS");
    end else begin
      $display("matrix_inverse_3x3_top_tb: FAIL");
    end
    $finish;
  end

endmodule
